/* hdl/env_sensor_compensation_defines.svh */
// Assertion macros used by the environmental sensor compensation checker.
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define ESC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("esc assertion failed");

// Next-cycle implication, reset-qualified.
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("esc assertion failed");

`endif

/* hdl/esc_pkg.sv */
// Types and constants for the environmental sensor compensation block.
package esc_pkg;

    localparam logic [2:0]  REG_TRIM_T      = 3'd0;
    localparam logic [2:0]  REG_TRIM_P_LO   = 3'd1;
    localparam logic [2:0]  REG_TRIM_P_HI   = 3'd2;
    localparam logic [2:0]  REG_TRIM_MIXED  = 3'd3;
    localparam logic [2:0]  REG_TRIM_H      = 3'd4;

    localparam logic [19:0] SKIP_20   = 20'h80000;
    localparam logic [15:0] SKIP_16   = 16'h8000;
    localparam logic [31:0] HUM_MAX   = 32'd419430400;
    localparam logic [63:0] T_FINE_P  = 64'd128000;
    localparam logic [63:0] P_BASE    = 64'd1048576;
    localparam logic [63:0] P_SCALE   = 64'd3125;
    localparam logic [31:0] T_FINE_H  = 32'd76800;
    localparam logic [31:0] H_RND15   = 32'd16384;
    localparam logic [31:0] H_OFS_B   = 32'd32768;
    localparam logic [31:0] H_OFS_C   = 32'd2097152;
    localparam logic [31:0] H_RND14   = 32'd8192;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_A, ST_T_B, ST_T_C, ST_T_OUT,
        ST_P_SQ, ST_P_SQ6, ST_P_P5, ST_P_SQ3, ST_P_P2, ST_P_P1, ST_P_CHK,
        ST_P_K, ST_P_DINIT, ST_P_DIV, ST_P_Q9, ST_P_Q9B, ST_P_P8, ST_P_FIN,
        ST_H_H5, ST_H_RND, ST_H_H6, ST_H_H3, ST_H_AB, ST_H_H2, ST_H_TD,
        ST_H_SS, ST_H_H1, ST_H_FIN,
        ST_DONE
    } t_state;

    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx8_64(input logic [7:0] x);
        return {{56{x[7]}}, x};
    endfunction

endpackage

/* hdl/env_sensor_compensation.sv */
// Top level: sequenced integer compensation of temperature, pressure and humidity.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | raw temperature, pressure, humidity
//  out     | source    | o_out_valid / i_out_stall  | compensated values and valid flags
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | trim word index and data
//
// In a beat with all three channels present, every product goes through one shared
// 64x16 multiplier (launch, four 16-bit passes, capture), 21 products in all, and the
// pressure quotient goes through a restoring divider. Skipped channels and a zero
// pressure divisor drop steps; a beat with every channel skipped goes straight from
// the idle step to the done step.
// Reset (synchronous, active low) clears the trim words, the fine temperature and all
// handshake state. The block holds o_in_stall high while a beat is in work; a finished
// result waits in the output register while the next beat is taken, and the sequencer
// holds in its done step while that register is full and stalled.
module env_sensor_compensation import esc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  logic [15:0] i_raw_humidity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic [16:0] o_humidity_q22_10,
    output logic        o_temperature_valid,
    output logic        o_pressure_valid,
    output logic        o_humidity_valid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Trim words and persistent fine temperature
    logic [47:0] r_trim_t;
    logic [63:0] r_trim_plo;
    logic [63:0] r_trim_phi;
    logic [47:0] r_trim_mx;
    logic [39:0] r_trim_h;
    logic [31:0] r_fine;

    t_state r_state, n_state;

    // Captured beat
    logic [19:0] r_rt, r_rp;
    logic [15:0] r_rh;
    logic        r_tv, r_pv, r_hv;

    // Working registers
    logic [31:0] r_x, r_y;
    logic [31:0] r_s0, r_s1, r_s2, r_s3;
    logic [63:0] r_sq, r_v2, r_acc, r_num, r_pp, r_c;
    logic [31:0] r_tout, r_pout;
    logic [16:0] r_hout;

    // Output register
    logic        r_ovalid;
    logic [31:0] r_o_t, r_o_p;
    logic [16:0] r_o_h;
    logic        r_o_tv, r_o_pv, r_o_hv;

    // Shared multiplier: 64x64 modulo 2^64, 16 multiplier bits per pass
    logic        r_mbusy, r_mdone;
    logic [1:0]  r_mcnt;
    logic [63:0] r_ma, r_mb, r_macc;
    logic [63:0] w_ma, w_mb;
    logic        w_mul_state, w_mstart;
    logic [79:0] w_part;
    logic [63:0] w_prod;
    logic [31:0] w_plo;

    // Divider
    logic [63:0] r_dq, r_dd;
    logic [64:0] r_rem;
    logic [5:0]  r_dcnt;
    logic        r_dneg;
    logic [64:0] w_rsh;
    logic        w_dge;
    logic [64:0] w_rnext;
    logic [63:0] w_qnext;

    // Trim fields
    logic [15:0] w_t1;
    logic [31:0] w_t2, w_t3;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [31:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;

    logic [63:0] w_v1c;
    logic [31:0] w_xh;
    logic [63:0] w_pp13;
    logic [31:0] w_hs;
    logic [31:0] w_hclamp;
    logic        w_out_free;
    t_state      w_after_t, w_after_p;

    assign w_t1 = r_trim_t[15:0];
    assign w_t2 = {{16{r_trim_t[31]}}, r_trim_t[31:16]};
    assign w_t3 = {{16{r_trim_t[47]}}, r_trim_t[47:32]};
    assign w_p1 = {48'd0, r_trim_plo[15:0]};
    assign w_p2 = sx16_64(r_trim_plo[31:16]);
    assign w_p3 = sx16_64(r_trim_plo[47:32]);
    assign w_p4 = sx16_64(r_trim_plo[63:48]);
    assign w_p5 = sx16_64(r_trim_phi[15:0]);
    assign w_p6 = sx16_64(r_trim_phi[31:16]);
    assign w_p7 = sx16_64(r_trim_phi[47:32]);
    assign w_p8 = sx16_64(r_trim_phi[63:48]);
    assign w_p9 = sx16_64(r_trim_mx[15:0]);
    assign w_h1 = {24'd0, r_trim_mx[23:16]};
    assign w_h2 = 32'(sx16_64(r_trim_mx[39:24]));
    assign w_h3 = {24'd0, r_trim_mx[47:40]};
    assign w_h4 = 32'(sx16_64(r_trim_h[15:0]));
    assign w_h5 = 32'(sx16_64(r_trim_h[31:16]));
    assign w_h6 = 32'(sx8_64(r_trim_h[39:32]));

    assign w_v1c  = {{32{r_fine[31]}}, r_fine} - T_FINE_P;
    assign w_xh   = r_fine - T_FINE_H;
    assign w_pp13 = $signed(r_pp) >>> 13;
    assign w_hs   = $signed(r_s3) >>> 15;

    assign w_part = r_ma * r_mb[15:0];
    assign w_prod = r_macc;
    assign w_plo  = r_macc[31:0];

    assign w_rsh   = {r_rem[63:0], r_dq[63]};
    assign w_dge   = (w_rsh >= {1'b0, r_dd});
    assign w_rnext = w_dge ? (w_rsh - {1'b0, r_dd}) : w_rsh;
    assign w_qnext = {r_dq[62:0], w_dge};

    assign w_hclamp = r_s3[31] ? 32'd0 : ((r_s3 > HUM_MAX) ? HUM_MAX : r_s3);

    assign w_after_t  = r_pv ? ST_P_SQ : (r_hv ? ST_H_H5 : ST_DONE);
    assign w_after_p  = r_hv ? ST_H_H5 : ST_DONE;
    assign w_out_free = !r_ovalid || !i_out_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration writes; out-of-range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_t   <= '0;
            r_trim_plo <= '0;
            r_trim_phi <= '0;
            r_trim_mx  <= '0;
            r_trim_h   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TRIM_T:     r_trim_t   <= i_cfg_data[47:0];
                REG_TRIM_P_LO:  r_trim_plo <= i_cfg_data;
                REG_TRIM_P_HI:  r_trim_phi <= i_cfg_data;
                REG_TRIM_MIXED: r_trim_mx  <= i_cfg_data[47:0];
                REG_TRIM_H:     r_trim_h   <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier operand select
    always_comb begin
        n_state     = r_state;
        w_mul_state = 1'b0;
        w_ma        = '0;
        w_mb        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_raw_temperature != SKIP_20) begin
                        n_state = ST_T_A;
                    end else if (i_raw_pressure != SKIP_20) begin
                        n_state = ST_P_SQ;
                    end else if (i_raw_humidity != SKIP_16) begin
                        n_state = ST_H_H5;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_T_A: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, {15'd0, r_rt[19:3]} - {15'd0, w_t1, 1'b0}};
                w_mb = {32'd0, w_t2};
                if (r_mdone) n_state = ST_T_B;
            end
            ST_T_B: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, {16'd0, r_rt[19:4]} - {16'd0, w_t1}};
                w_mb = w_ma;
                if (r_mdone) n_state = ST_T_C;
            end
            ST_T_C: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, r_y};
                w_mb = {32'd0, w_t3};
                if (r_mdone) n_state = ST_T_OUT;
            end
            ST_T_OUT: n_state = w_after_t;
            ST_P_SQ: begin
                w_mul_state = 1'b1;
                w_ma = w_v1c;
                w_mb = w_v1c;
                if (r_mdone) n_state = ST_P_SQ6;
            end
            ST_P_SQ6: begin
                w_mul_state = 1'b1;
                w_ma = r_sq;
                w_mb = w_p6;
                if (r_mdone) n_state = ST_P_P5;
            end
            ST_P_P5: begin
                w_mul_state = 1'b1;
                w_ma = w_v1c;
                w_mb = w_p5;
                if (r_mdone) n_state = ST_P_SQ3;
            end
            ST_P_SQ3: begin
                w_mul_state = 1'b1;
                w_ma = r_sq;
                w_mb = w_p3;
                if (r_mdone) n_state = ST_P_P2;
            end
            ST_P_P2: begin
                w_mul_state = 1'b1;
                w_ma = w_v1c;
                w_mb = w_p2;
                if (r_mdone) n_state = ST_P_P1;
            end
            ST_P_P1: begin
                w_mul_state = 1'b1;
                w_ma = (64'd1 << 47) + r_acc;
                w_mb = w_p1;
                if (r_mdone) n_state = ST_P_CHK;
            end
            ST_P_CHK: n_state = (r_acc == 64'd0) ? w_after_p : ST_P_K;
            ST_P_K: begin
                w_mul_state = 1'b1;
                w_ma = r_num;
                w_mb = P_SCALE;
                if (r_mdone) n_state = ST_P_DINIT;
            end
            ST_P_DINIT: n_state = ST_P_DIV;
            ST_P_DIV: begin
                if (r_dcnt == 6'd63) n_state = ST_P_Q9;
            end
            ST_P_Q9: begin
                w_mul_state = 1'b1;
                w_ma = w_p9;
                w_mb = w_pp13;
                if (r_mdone) n_state = ST_P_Q9B;
            end
            ST_P_Q9B: begin
                w_mul_state = 1'b1;
                w_ma = r_c;
                w_mb = w_pp13;
                if (r_mdone) n_state = ST_P_P8;
            end
            ST_P_P8: begin
                w_mul_state = 1'b1;
                w_ma = w_p8;
                w_mb = r_pp;
                if (r_mdone) n_state = ST_P_FIN;
            end
            ST_P_FIN: n_state = w_after_p;
            ST_H_H5: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, w_h5};
                w_mb = {32'd0, w_xh};
                if (r_mdone) n_state = ST_H_RND;
            end
            ST_H_RND: n_state = ST_H_H6;
            ST_H_H6: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, w_xh};
                w_mb = {32'd0, w_h6};
                if (r_mdone) n_state = ST_H_H3;
            end
            ST_H_H3: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, w_xh};
                w_mb = {32'd0, w_h3};
                if (r_mdone) n_state = ST_H_AB;
            end
            ST_H_AB: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, r_s1};
                w_mb = {32'd0, r_s2};
                if (r_mdone) n_state = ST_H_H2;
            end
            ST_H_H2: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, r_s1};
                w_mb = {32'd0, w_h2};
                if (r_mdone) n_state = ST_H_TD;
            end
            ST_H_TD: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, r_s0};
                w_mb = {32'd0, r_s2};
                if (r_mdone) n_state = ST_H_SS;
            end
            ST_H_SS: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, w_hs};
                w_mb = {32'd0, w_hs};
                if (r_mdone) n_state = ST_H_H1;
            end
            ST_H_H1: begin
                w_mul_state = 1'b1;
                w_ma = {32'd0, r_s1};
                w_mb = {32'd0, w_h1};
                if (r_mdone) n_state = ST_H_FIN;
            end
            ST_H_FIN: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Launch a product once per multiply step: not while busy, not on the done cycle
    assign w_mstart = w_mul_state && !r_mbusy && !r_mdone;

    // Shared multiplier: accumulate one 64x16 partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (w_mstart) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mstart) begin
            r_ma   <= w_ma;
            r_mb   <= w_mb;
            r_macc <= '0;
        end else if (r_mbusy) begin
            r_macc <= r_macc + w_part[63:0];
            r_ma   <= r_ma << 16;
            r_mb   <= r_mb >> 16;
        end
    end

    // Fine temperature persists across beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine <= '0;
        end else if (r_state == ST_T_C && r_mdone) begin
            r_fine <= r_x + 32'($signed(w_plo) >>> 14);
        end
    end

    // Datapath: capture the beat, each product into its working register, the divider steps and the results
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_rt   <= i_raw_temperature;
                    r_rp   <= i_raw_pressure;
                    r_rh   <= i_raw_humidity;
                    r_tv   <= (i_raw_temperature != SKIP_20);
                    r_pv   <= (i_raw_pressure != SKIP_20);
                    r_hv   <= (i_raw_humidity != SKIP_16);
                    r_tout <= '0;
                    r_pout <= '0;
                    r_hout <= '0;
                end
            end
            ST_T_A:   if (r_mdone) r_x <= 32'($signed(w_plo) >>> 11);
            ST_T_B:   if (r_mdone) r_y <= 32'($signed(w_plo) >>> 12);
            ST_T_OUT: r_tout <= 32'($signed((r_fine << 2) + r_fine + 32'd128) >>> 8);
            ST_P_SQ:  if (r_mdone) r_sq <= w_prod;
            ST_P_SQ6: if (r_mdone) r_v2 <= w_prod;
            ST_P_P5:  if (r_mdone) r_v2 <= r_v2 + (w_prod << 17) + (w_p4 << 35);
            ST_P_SQ3: if (r_mdone) r_acc <= 64'($signed(w_prod) >>> 8);
            ST_P_P2:  if (r_mdone) r_acc <= r_acc + (w_prod << 12);
            ST_P_P1:  if (r_mdone) r_acc <= 64'($signed(w_prod) >>> 33);
            ST_P_CHK: begin
                // Zero divisor gives zero pressure, still flagged valid
                r_pout <= '0;
                r_num  <= ((P_BASE - {44'd0, r_rp}) << 31) - r_v2;
            end
            ST_P_K:   if (r_mdone) r_num <= w_prod;
            ST_P_DINIT: begin
                r_dq   <= r_num[63] ? (64'd0 - r_num) : r_num;
                r_dd   <= r_acc[63] ? (64'd0 - r_acc) : r_acc;
                r_dneg <= r_num[63] ^ r_acc[63];
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            ST_P_DIV: begin
                r_rem  <= w_rnext;
                r_dq   <= w_qnext;
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) begin
                    r_pp <= r_dneg ? (64'd0 - w_qnext) : w_qnext;
                end
            end
            ST_P_Q9:  if (r_mdone) r_c <= w_prod;
            ST_P_Q9B: if (r_mdone) r_c <= 64'($signed(w_prod) >>> 25);
            ST_P_P8:  if (r_mdone) r_sq <= r_pp + r_c + 64'($signed(w_prod) >>> 19);
            ST_P_FIN: r_pout <= 32'(64'($signed(r_sq) >>> 8) + (w_p7 << 4));
            ST_H_H5:  if (r_mdone) r_s0 <= {2'd0, r_rh, 14'd0} - {w_h4[11:0], 20'd0} - w_plo;
            ST_H_RND: r_s0 <= 32'($signed(r_s0 + H_RND15) >>> 15);
            ST_H_H6:  if (r_mdone) r_s1 <= 32'($signed(w_plo) >>> 10);
            ST_H_H3:  if (r_mdone) r_s2 <= 32'($signed(w_plo) >>> 11) + H_OFS_B;
            ST_H_AB:  if (r_mdone) r_s1 <= 32'($signed(w_plo) >>> 10) + H_OFS_C;
            ST_H_H2:  if (r_mdone) r_s2 <= 32'($signed(w_plo + H_RND14) >>> 14);
            ST_H_TD:  if (r_mdone) r_s3 <= w_plo;
            ST_H_SS:  if (r_mdone) r_s1 <= 32'($signed(w_plo) >>> 7);
            ST_H_H1:  if (r_mdone) r_s3 <= r_s3 - 32'($signed(w_plo) >>> 4);
            ST_H_FIN: r_hout <= w_hclamp[28:12];
            default: ;
        endcase
    end

    // Output register: load when done and the slot is free, drop on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_o_t  <= r_tout;
            r_o_p  <= r_pout;
            r_o_h  <= r_hout;
            r_o_tv <= r_tv;
            r_o_pv <= r_pv;
            r_o_hv <= r_hv;
        end
    end

    assign o_out_valid         = r_ovalid;
    assign o_temperature_centi = r_o_t;
    assign o_pressure_q24_8    = r_o_p;
    assign o_humidity_q22_10   = r_o_h;
    assign o_temperature_valid = r_o_tv;
    assign o_pressure_valid    = r_o_pv;
    assign o_humidity_valid    = r_o_hv;

endmodule

/* hdl/esc_checker.sv */
// Port-level checker for the environmental sensor compensation block, with its bind.
`include "env_sensor_compensation_defines.svh"

module esc_checker import esc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_temperature_centi,
    input logic [31:0] o_pressure_q24_8,
    input logic [16:0] o_humidity_q22_10,
    input logic        o_temperature_valid,
    input logic        o_humidity_valid
);

    `ESC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ESC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_pressure_q24_8))
    `ESC_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ESC_ASSERT_NOW(a_skip_t_zero, i_clk, i_rst_n, o_out_valid && !o_temperature_valid, o_temperature_centi == 32'd0)
    `ESC_ASSERT_NOW(a_hum_range, i_clk, i_rst_n, o_out_valid && o_humidity_valid, o_humidity_q22_10 <= 17'd102400)

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_temperature_centi (o_temperature_centi),
    .o_pressure_q24_8    (o_pressure_q24_8),
    .o_humidity_q22_10   (o_humidity_q22_10),
    .o_temperature_valid (o_temperature_valid),
    .o_humidity_valid    (o_humidity_valid)
);

/* test/tb.sv */
// Self-checking testbench for the environmental sensor compensation block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    localparam int N_RANDOM    = 500;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 300;

    typedef struct packed {
        logic [19:0] rt;
        logic [19:0] rp;
        logic [15:0] rh;
    } t_reading;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] p;
        logic [16:0] h;
        logic        tv;
        logic        pv;
        logic        hv;
    } t_comp;

    // Directed row: reading plus an optional typed-in result.
    typedef struct packed {
        t_reading rd;
        logic     fixed;
        t_comp    res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [19:0] i_raw_temperature = '0;
    logic [19:0] i_raw_pressure = '0;
    logic [15:0] i_raw_humidity = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic [16:0] o_humidity_q22_10;
    logic        o_temperature_valid;
    logic        o_pressure_valid;
    logic        o_humidity_valid;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    env_sensor_compensation DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: trim words and fine temperature.
    logic [63:0] trim [5];
    logic [31:0] t_fine;

    t_comp comp_queue[$];
    int    n_fail = 0;
    int    n_checked = 0;
    int    n_skips = 0;
    int    n_cfg = 0;
    bit    hold_long = 0;

    function automatic logic [31:0] sra32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] temp_comp(logic [19:0] adc);
        logic [31:0] a32, t1, t2, t3, a, v1, b, v2;
        a32 = {12'd0, adc};
        t1 = {16'd0, trim[REG_TRIM_T][15:0]};
        t2 = {{16{trim[REG_TRIM_T][31]}}, trim[REG_TRIM_T][31:16]};
        t3 = {{16{trim[REG_TRIM_T][47]}}, trim[REG_TRIM_T][47:32]};
        a = (a32 >> 3) - (t1 << 1);
        v1 = sra32(a * t2, 11);
        b = (a32 >> 4) - t1;
        v2 = sra32(sra32(b * b, 12) * t3, 14);
        t_fine = v1 + v2;
        return sra32(t_fine * 32'd5 + 32'd128, 8);
    endfunction

    function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
        logic [63:0] un, ud, q;
        un = n[63] ? -n : n;
        ud = d[63] ? -d : d;
        q = un / ud;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic logic [31:0] press_comp(logic [19:0] adc);
        logic [63:0] lo, hi, p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
        lo = trim[REG_TRIM_P_LO];
        hi = trim[REG_TRIM_P_HI];
        p1 = {48'd0, lo[15:0]};
        p2 = {{48{lo[31]}}, lo[31:16]};
        p3 = {{48{lo[47]}}, lo[47:32]};
        p4 = {{48{lo[63]}}, lo[63:48]};
        p5 = {{48{hi[15]}}, hi[15:0]};
        p6 = {{48{hi[31]}}, hi[31:16]};
        p7 = {{48{hi[47]}}, hi[47:32]};
        p8 = {{48{hi[63]}}, hi[63:48]};
        p9 = {{48{trim[REG_TRIM_MIXED][15]}}, trim[REG_TRIM_MIXED][15:0]};
        v1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0)
            return 32'd0;
        p = 64'd1048576 - {44'd0, adc};
        p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
        v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
        v2 = sra64(p8 * p, 19);
        p = sra64(p + v1 + v2, 8) + (p7 << 4);
        return p[31:0];
    endfunction

    function automatic logic [16:0] hum_comp(logic [15:0] adc);
        logic [63:0] mx, hm;
        logic [31:0] h1, h2, h3, h4, h5, h6, x, t1, a, b, c, d, s;
        mx = trim[REG_TRIM_MIXED];
        hm = trim[REG_TRIM_H];
        h1 = {24'd0, mx[23:16]};
        h2 = {{16{mx[39]}}, mx[39:24]};
        h3 = {24'd0, mx[47:40]};
        h4 = {{16{hm[15]}}, hm[15:0]};
        h5 = {{16{hm[31]}}, hm[31:16]};
        h6 = {{24{hm[39]}}, hm[39:32]};
        x = t_fine - 32'd76800;
        t1 = ({16'd0, adc} << 14) - (h4 << 20) - (h5 * x);
        t1 = sra32(t1 + 32'd16384, 15);
        a = sra32(x * h6, 10);
        b = sra32(x * h3, 11) + 32'd32768;
        c = sra32(a * b, 10) + 32'd2097152;
        d = sra32(c * h2 + 32'd8192, 14);
        x = t1 * d;
        s = sra32(x, 15);
        x = x - sra32(sra32(s * s, 7) * h1, 4);
        if (x[31])
            x = 32'd0;
        if (x > HUM_MAX)
            x = HUM_MAX;
        return x[28:12];
    endfunction

    // Compensate one reading; temperature first, it moves the fine temperature.
    function automatic t_comp compensate(t_reading rd);
        t_comp r;
        r = '0;
        r.tv = rd.rt != SKIP_20;
        r.pv = rd.rp != SKIP_20;
        r.hv = rd.rh != SKIP_16;
        if (r.tv)
            r.t = temp_comp(rd.rt);
        if (r.pv)
            r.p = press_comp(rd.rp);
        if (r.hv)
            r.h = hum_comp(rd.rh);
        return r;
    endfunction

    // Write one trim word while the block is idle.
    task automatic write_trim(logic [2:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_TRIM_T, REG_TRIM_MIXED: trim[idx] = data & 64'hFFFF_FFFF_FFFF;
            REG_TRIM_H:                 trim[idx] = data & 64'hFF_FFFF_FFFF;
            REG_TRIM_P_LO, REG_TRIM_P_HI: trim[idx] = data;
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Offer one beat; hold it until accepted.
    task automatic send_reading(t_reading rd, bit fixed, t_comp res);
        t_comp pred;
        pred = compensate(rd);
        if (fixed && pred != res) begin
            n_fail++;
            $display("directed row disagrees with predictor: %h vs %h", res, pred);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        {i_raw_temperature, i_raw_pressure, i_raw_humidity} = rd;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        comp_queue.push_back(fixed ? res : pred);
        if (!pred.tv || !pred.pv || !pred.hv)
            n_skips++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained;
        while (comp_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic random_gap;
        repeat ($urandom_range(0, 15)) @(negedge i_clk);
    endtask

    function automatic t_reading rand_reading;
        t_reading rd;
        int sel;
        rd.rt = 20'($urandom_range(0, 20'hFFFFF));
        rd.rp = 20'($urandom_range(0, 20'hFFFFF));
        rd.rh = 16'($urandom_range(0, 16'hFFFF));
        // Plausible conversions in half the beats, full-range values otherwise, some skip codes mixed in.
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            rd.rt = 20'($urandom_range(20'h70000, 20'h90000));
            rd.rp = 20'($urandom_range(20'h40000, 20'h60000));
            rd.rh = 16'($urandom_range(16'h5000, 16'h9000));
        end
        if ($urandom_range(0, 9) == 0) rd.rt = SKIP_20;
        if ($urandom_range(0, 9) == 0) rd.rp = SKIP_20;
        if ($urandom_range(0, 9) == 0) rd.rh = SKIP_16;
        return rd;
    endfunction

    task automatic load_typical;
        write_trim(REG_TRIM_T, {16'hFC18, 16'h6712, 16'h6F12});
        write_trim(REG_TRIM_P_LO, {16'h1F15, 16'h0BD0, 16'hD6E3, 16'h8E7A});
        write_trim(REG_TRIM_P_HI, {16'h0F3C, 16'hFFF9, 16'hFFF9, 16'h00A3});
        write_trim(REG_TRIM_MIXED, {8'h00, 16'h0164, 8'h4B, 16'h1770});
        write_trim(REG_TRIM_H, {8'h1E, 16'h0032, 16'h0148});
    endtask

    task automatic load_random;
        write_trim(REG_TRIM_T, {$urandom, $urandom});
        write_trim(REG_TRIM_P_LO, {$urandom, $urandom});
        write_trim(REG_TRIM_P_HI, {$urandom, $urandom});
        write_trim(REG_TRIM_MIXED, {$urandom, $urandom});
        write_trim(REG_TRIM_H, {$urandom, $urandom});
    endtask

    // Output side: random stall runs, plus one long hold-off.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_out_stall = 1'b1;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                i_out_stall = gap != 0;
                repeat (gap) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        repeat (200) @(posedge i_clk);
        hold_long = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_long = 1'b0;
    end

    // Compare each accepted output beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_comp got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_temperature_centi, o_pressure_q24_8, o_humidity_q22_10,
                   o_temperature_valid, o_pressure_valid, o_humidity_valid};
            if (comp_queue.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected output beat %h", got);
            end else begin
                want = comp_queue.pop_front();
                n_checked++;
                if (got != want) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch T %h/%h P %h/%h H %h/%h flags %b/%b",
                                 want.t, got.t, want.p, got.p, want.h, got.h,
                                 {want.tv, want.pv, want.hv}, {got.tv, got.pv, got.hv});
                end
            end
        end
    end

    // Watchdog on a cycle count.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout with %0d beats outstanding", comp_queue.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row row;
        foreach (trim[i]) trim[i] = '0;
        t_fine = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // All trim words zero: pressure divisor is zero, humidity comes out zero.
        row = '0;
        row.rd = {20'd0, 20'd0, 16'd0};
        row.fixed = 1'b1;
        row.res = {32'd0, 32'd0, 17'd0, 3'b111};
        rows.push_back(row);
        row.rd = {SKIP_20, SKIP_20, SKIP_16};
        row.res = {32'd0, 32'd0, 17'd0, 3'b000};
        rows.push_back(row);
        row.rd = {20'hFFFFF, 20'hFFFFF, 16'hFFFF};
        row.res = {32'd0, 32'd0, 17'd0, 3'b111};
        rows.push_back(row);
        foreach (rows[i]) send_reading(rows[i].rd, rows[i].fixed, rows[i].res);
        wait_drained();

        // Typical trims, then extremes; rows checked against the predictor.
        load_typical();
        rows.delete();
        row = '0;
        row.rd = {20'h7E000, 20'h51000, 16'h6E00}; rows.push_back(row);
        row.rd = {20'h00000, 20'h00000, 16'h0000}; rows.push_back(row);
        row.rd = {20'hFFFFF, 20'hFFFFF, 16'hFFFF}; rows.push_back(row);
        row.rd = {SKIP_20, 20'h51000, 16'h6E00};   rows.push_back(row);
        row.rd = {20'h7E000, SKIP_20, 16'h6E00};   rows.push_back(row);
        row.rd = {20'h7E000, 20'h51000, SKIP_16};  rows.push_back(row);
        row.rd = {20'h7FFFF, 20'h80001, 16'h7FFF}; rows.push_back(row);
        foreach (rows[i]) send_reading(rows[i].rd, 1'b0, '0);
        wait_drained();

        write_trim(REG_TRIM_T, 64'hFFFF_FFFF_FFFF);
        write_trim(REG_TRIM_P_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(REG_TRIM_P_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_trim(REG_TRIM_MIXED, 64'hFFFF_FFFF_FFFF);
        write_trim(REG_TRIM_H, 64'hFF_FFFF_FFFF);
        foreach (rows[i]) send_reading(rows[i].rd, 1'b0, '0);
        wait_drained();

        // Random part in phases, trims reloaded (typical or random) per phase; drain between phases.
        load_typical();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i > 0 && i % 100 == 0) begin
                wait_drained();
                if (i % 200 == 0) load_random(); else load_typical();
            end
            random_gap();
            send_reading(rand_reading(), 1'b0, '0);
        end
        wait_drained();

        $display("checked %0d beats (%0d with skipped channels), %0d trim writes",
                 n_checked, n_skips, n_cfg);
        if (n_fail == 0 && comp_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/esc_pkg.sv
hdl/env_sensor_compensation.sv
hdl/esc_checker.sv
test/tb.sv
